// File: sv/bol_pkg.sv
// Shared widths and codes for the bounded ordered list.
package bol_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REM_VALUE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_LIST      = 3'd5;

  localparam logic [STATUS_W-1:0] STS_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_LISTED    = 3'd4;

endpackage

// File: sv/bol_if.sv
// Request and response channel interfaces of the bounded ordered list.
interface bol_req_if;
  logic                               valid;
  logic                               ready;
  logic [bol_pkg::ACTION_W-1:0]       action;
  logic signed [bol_pkg::FIELD_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface bol_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [bol_pkg::STATUS_W-1:0]       status;
  logic signed [bol_pkg::FIELD_W-1:0] element;
  logic [bol_pkg::COUNT_W-1:0]        entry_count;
  logic                               last;

  modport source (output valid, status, element, entry_count, last, input ready);
  modport sink   (input valid, status, element, entry_count, last, output ready);
endinterface

// File: sv/bol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bounded_ordered_list.sv
// Top level of the bounded ordered list: ring store, sequencer and response register.
//
// Usage:
//   req_i carries one action per beat (insert front/back, remove front/back,
//   remove first matching value, list). rsp_o carries the result beats; the
//   final beat of each action has last set, and entry_count gives the number
//   of entries held after the action.
//   The entries sit in a RAM used as a ring behind a head index and a count.
//   One ring address adder and one value comparator are reused every cycle.
//   req_i.ready is high only while the sequencer is idle.
//   The list action gives one element beat per cycle while rsp_o is not
//   stalled. Remove value scans from the head for the first match and, when
//   found, closes up the gap behind it; the scan reads one entry a cycle and
//   the close-up moves one entry a cycle through the RAM's single read and
//   write port.
//   Reset empties the list at once; no clearing pass is needed.
//   A stall on rsp_o holds the response register; the sequencer waits for it
//   to drain before it loads the next beat, and nothing is dropped.
module bounded_ordered_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bol_req_if.sink   req_i,
  bol_rsp_if.source rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RESP   = 3'd1;
  localparam logic [2:0] ST_LIST   = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [AW-1:0]                 tgt_q, tgt_d;
  logic [AW-1:0]                 rd_addr_q;
  logic [bol_pkg::STATUS_W-1:0]  resp_q, resp_d;
  logic [VALUE_BITS-1:0]         val_q, val_d;

  logic                          out_v_q;
  logic [bol_pkg::STATUS_W-1:0]  out_sts_q;
  logic [bol_pkg::FIELD_W-1:0]   out_elem_q;
  logic [bol_pkg::COUNT_W-1:0]   out_cnt_q;
  logic                          out_last_q;

  logic                          out_load;
  logic [bol_pkg::STATUS_W-1:0]  ld_sts;
  logic [bol_pkg::FIELD_W-1:0]   ld_elem;
  logic                          ld_last;
  logic                          slot_free;
  logic                          accept;

  logic [CW-1:0]                 ring_off;
  logic [CW:0]                   ring_sum;
  logic [AW-1:0]                 ring_addr;
  logic [CW-1:0]                 idx_nx;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [VALUE_BITS-1:0]         wdata;
  logic [VALUE_BITS-1:0]         rd_data;
  logic signed [63:0]            wide_in;
  logic signed [63:0]            wide_rd;
  logic                          hit;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_v_q || rsp_o.ready;
  assign idx_nx    = idx_q + CW'(1);
  assign wide_in   = 64'(req_i.value);
  assign wide_rd   = 64'($signed(rd_data));
  assign hit       = (rd_data == val_q);

  // ring address unit: head plus offset, wrapped once
  assign ring_off  = (state_q == ST_IDLE && req_i.action == bol_pkg::ACT_INS_BACK)
                     ? count_q : idx_d;
  assign ring_sum  = (CW+1)'(head_q) + (CW+1)'(ring_off);
  assign ring_addr = (ring_sum >= (CW+1)'(DEPTH)) ? AW'(ring_sum - (CW+1)'(DEPTH))
                                                   : AW'(ring_sum);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    resp_d   = resp_q;
    val_d    = val_q;
    we       = 1'b0;
    waddr    = ring_addr;
    wdata    = wide_in[VALUE_BITS-1:0];
    out_load = 1'b0;
    ld_sts   = bol_pkg::STS_DONE;
    ld_elem  = '0;
    ld_last  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        idx_d  = '0;
        val_d  = wide_in[VALUE_BITS-1:0];
        resp_d = bol_pkg::STS_DONE;
        if (accept) begin
          state_d = ST_RESP;
          case (req_i.action)
            bol_pkg::ACT_INS_FRONT, bol_pkg::ACT_INS_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                resp_d = bol_pkg::STS_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
                if (req_i.action == bol_pkg::ACT_INS_FRONT) begin
                  head_d = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
                  waddr  = head_d;
                end
              end
            end
            bol_pkg::ACT_REM_FRONT, bol_pkg::ACT_REM_BACK: begin
              if (count_q == '0) begin
                resp_d = bol_pkg::STS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (req_i.action == bol_pkg::ACT_REM_FRONT) begin
                  head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
                end
              end
            end
            bol_pkg::ACT_REM_VALUE: begin
              if (count_q == '0) begin
                resp_d = bol_pkg::STS_EMPTY;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            bol_pkg::ACT_LIST: begin
              if (count_q == '0) begin
                resp_d = bol_pkg::STS_EMPTY;
              end else begin
                state_d = ST_LIST;
              end
            end
            default: begin
              resp_d = bol_pkg::STS_DONE;
            end
          endcase
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_sts   = resp_q;
          state_d  = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_sts   = bol_pkg::STS_LISTED;
          ld_elem  = wide_rd[bol_pkg::FIELD_W-1:0];
          ld_last  = (idx_nx == count_q);
          idx_d    = idx_nx;
          if (ld_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        idx_d = idx_nx;
        if (hit) begin
          tgt_d   = rd_addr_q;
          state_d = ST_SHIFT;
        end else if (idx_nx == count_q) begin
          resp_d  = bol_pkg::STS_NOT_FOUND;
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (idx_q == count_q) begin
          count_d = count_q - CW'(1);
          resp_d  = bol_pkg::STS_DONE;
          state_d = ST_RESP;
        end else begin
          we    = 1'b1;
          waddr = tgt_q;
          wdata = rd_data;
          tgt_d = rd_addr_q;
          idx_d = idx_nx;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  bol_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ring_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    resp_q    <= resp_d;
    val_q     <= val_d;
    rd_addr_q <= ring_addr;
    if (out_load) begin
      out_sts_q  <= ld_sts;
      out_elem_q <= ld_elem;
      out_cnt_q  <= bol_pkg::COUNT_W'(count_q);
      out_last_q <= ld_last;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = out_sts_q;
  assign rsp_o.element     = out_elem_q;
  assign rsp_o.entry_count = out_cnt_q;
  assign rsp_o.last        = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(DEPTH - 1))
    else $error("head index beyond depth");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && count_q == CW'(DEPTH) &&
     (req_i.action == bol_pkg::ACT_INS_FRONT || req_i.action == bol_pkg::ACT_INS_BACK))
    |=> (count_q == $past(count_q) && head_q == $past(head_q)))
    else $error("insert into full list changed state");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST || state_q == ST_SEARCH) |-> (count_q != '0 && idx_q < count_q))
    else $error("walk over empty or past end of list");
`endif

endmodule

// File: tb/sv/bounded_ordered_list_tb.sv
// Self-checking testbench of the bounded ordered list: directed rows, then random actions.
module bounded_ordered_list_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 106;
  localparam int unsigned DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic [bol_pkg::ACTION_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [bol_pkg::ACTION_W-1:0] ACT_SPARE7 = 3'd7;

  localparam logic signed [bol_pkg::FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [bol_pkg::FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int unsigned PH_FILL  = 0;
  localparam int unsigned PH_DRAIN = 1;
  localparam int unsigned PH_MIX   = 2;

  typedef struct packed {
    logic [bol_pkg::STATUS_W-1:0]       status;
    logic signed [bol_pkg::FIELD_W-1:0] element;
    logic [bol_pkg::COUNT_W-1:0]        entry_count;
    logic                               last;
  } list_beat_t;

  typedef struct packed {
    logic [bol_pkg::ACTION_W-1:0]       action;
    logic signed [bol_pkg::FIELD_W-1:0] value;
    logic                               known;
    logic [bol_pkg::STATUS_W-1:0]       status;
    logic [bol_pkg::COUNT_W-1:0]        entry_count;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  bol_req_if req ();
  bol_rsp_if rsp ();

  bounded_ordered_list #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_BITS (bol_pkg::FIELD_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  logic signed [bol_pkg::FIELD_W-1:0] ring_store [LIST_DEPTH];
  int unsigned                        ring_head;
  int unsigned                        ring_held;
  list_beat_t                         pending_beats [$];
  stim_row_t                          directed_rows [$];
  int unsigned                        mismatches;
  int unsigned                        cycle_count;
  int unsigned                        burst_left;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic void push_beat(logic [bol_pkg::STATUS_W-1:0] st,
                                    logic signed [bol_pkg::FIELD_W-1:0] el,
                                    logic lst);
    pending_beats.push_back(list_beat_t'{st, el, bol_pkg::COUNT_W'(ring_held), lst});
  endfunction

  function automatic void apply_action(logic [bol_pkg::ACTION_W-1:0] act,
                                       logic signed [bol_pkg::FIELD_W-1:0] val);
    int unsigned pos;
    int unsigned j;
    case (act)
      bol_pkg::ACT_INS_FRONT, bol_pkg::ACT_INS_BACK: begin
        if (ring_held >= LIST_DEPTH) begin
          push_beat(bol_pkg::STS_FULL, '0, 1'b1);
        end else begin
          if (act == bol_pkg::ACT_INS_FRONT) begin
            ring_head = (ring_head + LIST_DEPTH - 1) % LIST_DEPTH;
            ring_store[ring_head] = val;
          end else begin
            ring_store[(ring_head + ring_held) % LIST_DEPTH] = val;
          end
          ring_held++;
          push_beat(bol_pkg::STS_DONE, '0, 1'b1);
        end
      end
      bol_pkg::ACT_REM_FRONT, bol_pkg::ACT_REM_BACK: begin
        if (ring_held == 0) begin
          push_beat(bol_pkg::STS_EMPTY, '0, 1'b1);
        end else begin
          if (act == bol_pkg::ACT_REM_FRONT) ring_head = (ring_head + 1) % LIST_DEPTH;
          ring_held--;
          push_beat(bol_pkg::STS_DONE, '0, 1'b1);
        end
      end
      bol_pkg::ACT_REM_VALUE: begin
        if (ring_held == 0) begin
          push_beat(bol_pkg::STS_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < ring_held && ring_store[(ring_head + pos) % LIST_DEPTH] != val) pos++;
          if (pos >= ring_held) begin
            push_beat(bol_pkg::STS_NOT_FOUND, '0, 1'b1);
          end else begin
            for (j = pos; j + 1 < ring_held; j++)
              ring_store[(ring_head + j) % LIST_DEPTH] =
                ring_store[(ring_head + j + 1) % LIST_DEPTH];
            ring_held--;
            push_beat(bol_pkg::STS_DONE, '0, 1'b1);
          end
        end
      end
      bol_pkg::ACT_LIST: begin
        if (ring_held == 0) begin
          push_beat(bol_pkg::STS_EMPTY, '0, 1'b1);
        end else begin
          for (j = 0; j < ring_held; j++)
            push_beat(bol_pkg::STS_LISTED, ring_store[(ring_head + j) % LIST_DEPTH],
                      j + 1 == ring_held);
        end
      end
      default: push_beat(bol_pkg::STS_DONE, '0, 1'b1);
    endcase
  endfunction

  function automatic logic signed [bol_pkg::FIELD_W-1:0] pick_value(bit from_store);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (from_store && ring_held != 0 && roll < 50)
      return ring_store[(ring_head + $urandom_range(0, ring_held - 1)) % LIST_DEPTH];
    if (roll < 75) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return -32'sd1;
        2:       return 32'sd1;
        3:       return VAL_MAX;
        4:       return VAL_MIN;
        default: return 32'sd42;
      endcase
    end
    return $urandom;
  endfunction

  // mixed phase: every code, spare ones included
  function automatic logic [bol_pkg::ACTION_W-1:0] mixed_action(int unsigned roll);
    if (roll < 94) return bol_pkg::ACTION_W'(roll % 6);
    return (roll < 97) ? ACT_SPARE6 : ACT_SPARE7;
  endfunction

  // caller sits on a falling edge; returns on a falling edge after the beat, later when a burst ends with an idle gap
  task automatic send_action(logic [bol_pkg::ACTION_W-1:0] act,
                             logic signed [bol_pkg::FIELD_W-1:0] val,
                             stim_row_t row);
    req.valid  = 1'b1;
    req.action = act;
    req.value  = val;
    do @(posedge clk_i); while (!req.ready);
    apply_action(act, val);
    if (row.known)
      pending_beats[$] = list_beat_t'{row.status, '0, row.entry_count, 1'b1};
    @(negedge clk_i);
    if (burst_left == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // receiver stall pattern: change mode every stretch
  int unsigned ready_mode;
  int unsigned ready_left;
  initial begin
    ready_mode = 0;
    ready_left = 0;
  end
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(10, 60);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       rsp.ready = 1'b1;
      1:       rsp.ready = ($urandom_range(0, 99) < 70);
      2:       rsp.ready = ($urandom_range(0, 99) < 25);
      default: rsp.ready = (cycle_count[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk_i) begin
    list_beat_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat status=%0d element=%0d count=%0d last=%0b", $time,
                 rsp.status, rsp.element, rsp.entry_count, rsp.last);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          mismatches++;
        end
        if (rsp.element !== want.element) begin
          $display("%0t: element expected %0d actual %0d", $time, want.element, rsp.element);
          mismatches++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   rsp.entry_count);
          mismatches++;
        end
        if (rsp.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, rsp.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("bounded_ordered_list_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned phase_left;
    int unsigned roll;
    int unsigned n;
    logic [bol_pkg::ACTION_W-1:0]       act;
    logic signed [bol_pkg::FIELD_W-1:0] val;
    stim_row_t                          no_row;

    cycle_count = 0;
    mismatches  = 0;
    ring_head   = 0;
    ring_held   = 0;
    burst_left  = 0;
    no_row      = '0;
    for (n = 0; n < LIST_DEPTH; n++) ring_store[n] = '0;
    rst_ni      = 1'b0;
    req.valid   = 1'b0;
    req.action  = bol_pkg::ACT_INS_FRONT;
    req.value   = '0;
    rsp.ready   = 1'b0;

    directed_rows.push_back('{bol_pkg::ACT_LIST,      32'sd0,  1'b1, bol_pkg::STS_EMPTY, 5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_FRONT, 32'sd0,  1'b1, bol_pkg::STS_EMPTY, 5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_BACK,  -32'sd1, 1'b1, bol_pkg::STS_EMPTY, 5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, 32'sd0,  1'b1, bol_pkg::STS_EMPTY, 5'd0});
    directed_rows.push_back('{ACT_SPARE6,             -32'sd1, 1'b1, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{ACT_SPARE7,             32'sd0,  1'b1, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_INS_FRONT, VAL_MAX, 1'b1, bol_pkg::STS_DONE,  5'd1});
    directed_rows.push_back('{bol_pkg::ACT_LIST,      32'sd0,  1'b0, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_BACK,  32'sd0,  1'b1, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_INS_BACK,  VAL_MIN, 1'b1, bol_pkg::STS_DONE,  5'd1});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, VAL_MIN, 1'b1, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_INS_FRONT, 32'sd0,  1'b1, bol_pkg::STS_DONE,  5'd1});
    directed_rows.push_back('{bol_pkg::ACT_REM_FRONT, -32'sd1, 1'b1, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_INS_BACK,  -32'sd1, 1'b1, bol_pkg::STS_DONE,  5'd1});
    directed_rows.push_back('{bol_pkg::ACT_INS_FRONT, 32'sd1,  1'b1, bol_pkg::STS_DONE,  5'd2});
    directed_rows.push_back('{bol_pkg::ACT_INS_BACK,  32'sd1,  1'b1, bol_pkg::STS_DONE,  5'd3});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, 32'sd5,  1'b1,
                              bol_pkg::STS_NOT_FOUND, 5'd3});
    directed_rows.push_back('{bol_pkg::ACT_LIST,      VAL_MIN, 1'b0, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, 32'sd1,  1'b0, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_LIST,      VAL_MAX, 1'b0, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{ACT_SPARE7,             VAL_MIN, 1'b1, bol_pkg::STS_DONE,  5'd2});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, -32'sd1, 1'b0, bol_pkg::STS_DONE,  5'd0});
    directed_rows.push_back('{bol_pkg::ACT_REM_VALUE, VAL_MAX, 1'b1,
                              bol_pkg::STS_NOT_FOUND, 5'd1});
    directed_rows.push_back('{bol_pkg::ACT_LIST,      32'sd0,  1'b0, bol_pkg::STS_DONE,  5'd0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_action(directed_rows[i].action, directed_rows[i].value, directed_rows[i]);

    // random phases; open with a fill so the full list is reached early
    phase      = PH_FILL;
    phase_left = 30;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(PH_FILL, PH_MIX);
        phase_left = $urandom_range(12, 30);
      end else begin
        phase_left--;
      end
      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  act = (roll < 85) ? ($urandom_range(0, 1) ? bol_pkg::ACT_INS_BACK
                                                            : bol_pkg::ACT_INS_FRONT) :
                        (roll < 92) ? bol_pkg::ACT_LIST :
                        (roll < 97) ? bol_pkg::ACT_REM_VALUE :
                        ($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7);
        PH_DRAIN: act = (roll < 25) ? bol_pkg::ACT_REM_FRONT :
                        (roll < 50) ? bol_pkg::ACT_REM_BACK :
                        (roll < 80) ? bol_pkg::ACT_REM_VALUE :
                        (roll < 92) ? bol_pkg::ACT_LIST : bol_pkg::ACT_INS_BACK;
        default:  act = mixed_action(roll);
      endcase
      if (act == bol_pkg::ACT_REM_VALUE)
        val = pick_value(1'b1);
      else
        val = pick_value(1'b0);
      send_action(act, val, no_row);
    end
    req.valid = 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bounded_ordered_list_tb: done, clean");
    end else begin
      $display("bounded_ordered_list_tb: done, errors");
    end
    $finish;
  end

endmodule
